/* sv/aps_pkg.sv */
// Shared types, constants and elaboration-time helpers for the aperture point sampler.
package aps_pkg;

  typedef struct packed {
    logic [23:0] u_angle;
    logic [23:0] u_radius;
  } aps_in_t;

  typedef struct packed {
    logic signed [23:0] x_coord;
    logic signed [23:0] y_coord;
    logic               inside_res;
    logic [15:0]        density;
  } aps_out_t;

  typedef enum logic {
    REG_BLADE_COUNT    = 1'b0,
    REG_BLADE_ROTATION = 1'b1
  } aps_reg_t;

  localparam int CORDIC_STEPS    = 30;
  localparam int STEPS_PER_STAGE = 2;
  localparam int CORDIC_STAGES   = CORDIC_STEPS / STEPS_PER_STAGE;
  localparam int ROOT_BITS       = 32;
  localparam int ROOT_STAGES     = ROOT_BITS / STEPS_PER_STAGE;
  // input reg + root/divide stages + CORDIC (gain, rotations, quadrant) + output reg
  localparam int LATENCY         = 1 + ROOT_STAGES + CORDIC_STAGES + 2 + 1;

  localparam logic [29:0] GAIN_Q30     = 30'd652032874;
  localparam logic [15:0] DISK_DENSITY = 16'd20861;

  localparam logic [29:0] STEP_TURNS [CORDIC_STEPS] = '{
    30'h20000000, 30'h12E4051D, 30'h09FB385B, 30'h051111D4, 30'h028B0D43, 30'h0145D7E1,
    30'h00A2F61E, 30'h00517C55, 30'h0028BE53, 30'h00145F2E, 30'h000A2F98, 30'h000517CC,
    30'h00028BE6, 30'h000145F3, 30'h0000A2F9, 30'h0000517C, 30'h000028BE, 30'h0000145F,
    30'h00000A2F, 30'h00000517, 30'h0000028B, 30'h00000145, 30'h000000A2, 30'h00000051,
    30'h00000028, 30'h00000014, 30'h0000000A, 30'h00000005, 30'h00000002, 30'h00000001
  };

  // Bitwise long division, used only for table constants.
  function automatic longint unsigned udiv64(longint unsigned a, longint unsigned b);
    longint unsigned q;
    longint unsigned r;
    q = 64'd0;
    r = 64'd0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], a[i]};
      if (r >= b) begin
        r = r - b;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // Same CORDIC as the datapath at magnitude 1.0 (Q30).
  function automatic longint cordic_const(logic [31:0] ang, logic want_sin);
    longint x;
    longint y;
    longint z;
    longint dx;
    longint dy;
    longint c;
    longint s;
    x = longint'(GAIN_Q30);
    y = 64'sd0;
    z = longint'(ang[29:0]);
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - longint'(STEP_TURNS[i]);
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + longint'(STEP_TURNS[i]);
      end
    end
    case (ang[31:30])
      2'd0:    begin c = x;  s = y;  end
      2'd1:    begin c = -y; s = x;  end
      2'd2:    begin c = -x; s = -y; end
      default: begin c = y;  s = -x; end
    endcase
    return want_sin ? s : c;
  endfunction

  // cos of half a sector, the polygon edge distance.
  function automatic longint rc_const(int n);
    longint unsigned half;
    half = udiv64(64'd1 << 31, longint'(n));
    return cordic_const(half[31:0], 1'b0);
  endfunction

  function automatic logic [15:0] dens_const(int n);
    longint unsigned full;
    longint          s;
    longint          den;
    longint unsigned d;
    full = udiv64(64'd1 << 32, longint'(n));
    s    = cordic_const(full[31:0], 1'b1);
    den  = longint'(n) * s;
    if (den <= 0) return 16'hFFFF;
    d = udiv64((64'd1 << 47) + longint'(den >>> 1), den);
    if (d > 64'd65535) return 16'hFFFF;
    return d[15:0];
  endfunction

endpackage

/* sv/aperture_point_sampler.sv */
// Top level: disk / polygon aperture point sampler, fully pipelined.
//
// One transaction per clock: start is taken in every cycle (busy is always low)
// and each transaction yields exactly one result, strobed by done for one cycle.
// Each result passes the input register, the 16-stage square-root and
// sector-divide pipeline (two bits per stage), the 17-stage CORDIC (gain
// multiply, 15 rotation stages of two steps, quadrant fold) and the output
// register. The receiver cannot stall, so there is no backpressure path.
// No memories, no clearing pass after reset. blade_count and blade_rotation are
// to be written only while no transaction is in flight.
module aperture_point_sampler #(
  parameter int MAX_BLADES = 16,
  parameter int FRAC_BITS  = 24
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  aps_pkg::aps_in_t  item,
  output logic              busy,
  output logic              done,
  output aps_pkg::aps_out_t result,
  input  logic              wr_en,
  input  logic [0:0]        wr_index,
  input  logic [15:0]       wr_data
);

  localparam int NW = $clog2(MAX_BLADES + 1);
  localparam int AW = (FRAC_BITS < 24) ? FRAC_BITS : 24;
  localparam int NR = aps_pkg::ROOT_STAGES;
  localparam logic [23:0] DRAW_MASK = 24'((64'd1 << AW) - 64'd1);

  // configuration
  logic [4:0]  blade_count;
  logic [15:0] blade_rotation;

  always_ff @(posedge clk) begin
    if (rst) begin
      blade_count    <= '0;
      blade_rotation <= '0;
    end else if (wr_en) begin
      unique case (wr_index)
        aps_pkg::REG_BLADE_COUNT:    blade_count    <= wr_data[4:0];
        aps_pkg::REG_BLADE_ROTATION: blade_rotation <= wr_data;
        default: ;
      endcase
    end
  end

  // effective blade count, clamped to [3, MAX_BLADES]
  logic [NW-1:0] n_eff;
  always_comb begin
    if (blade_count < 5'd3) begin
      n_eff = NW'(3);
    end else if (32'(blade_count) > MAX_BLADES) begin
      n_eff = NW'(MAX_BLADES);
    end else begin
      n_eff = NW'(blade_count);
    end
  end

  assign busy = 1'b0;

  // input stage: angle in turns, radicand, place within the sector
  logic [23:0] ua;
  logic [23:0] ur;
  logic [31:0] ang_in;
  logic [31:0] theta;
  logic [31:0] f_in;

  assign ua     = item.u_angle & DRAW_MASK;
  assign ur     = item.u_radius & DRAW_MASK;
  assign ang_in = 32'({8'd0, ua} << (32 - FRAC_BITS));
  assign theta  = ang_in - {blade_rotation, 16'd0};
  assign f_in   = theta * 32'(n_eff);

  // per-stage pipeline of the root and the divide
  logic              v_p   [NR+1];
  logic [31:0]       ang_p [NR+1];
  logic [63:0]       rad_p [NR+1];
  logic [35:0]       rm_p  [NR+1];
  logic [31:0]       rt_p  [NR+1];
  logic [31:0]       dd_p  [NR+1];
  logic [NW:0]       dr_p  [NR+1];
  logic [31:0]       dq_p  [NR+1];
  logic              dn_p  [NR+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v_p[0] <= 1'b0;
    end else begin
      v_p[0] <= start && !busy;
    end
    ang_p[0] <= ang_in;
    rad_p[0] <= 64'({40'd0, ur}) << (60 - FRAC_BITS);
    rm_p[0]  <= '0;
    rt_p[0]  <= '0;
    // offset from sector middle: sign and magnitude of f - 2^31
    dn_p[0]  <= !f_in[31];
    dd_p[0]  <= f_in[31] ? {1'b0, f_in[30:0]} : (32'h8000_0000 - f_in);
    dr_p[0]  <= '0;
    dq_p[0]  <= '0;
  end

  for (genvar k = 0; k < NR; k++) begin : g_rd
    logic [63:0] rad_n;
    logic [35:0] rm_n;
    logic [31:0] rt_n;
    logic [31:0] dd_n;
    logic [NW:0] dr_n;
    logic [31:0] dq_n;

    always_comb begin
      logic [35:0] trial;
      rad_n = rad_p[k];
      rm_n  = rm_p[k];
      rt_n  = rt_p[k];
      dd_n  = dd_p[k];
      dr_n  = dr_p[k];
      dq_n  = dq_p[k];
      for (int j = 0; j < aps_pkg::STEPS_PER_STAGE; j++) begin
        // square root, one result bit
        rm_n  = {rm_n[33:0], rad_n[63:62]};
        rad_n = {rad_n[61:0], 2'b00};
        trial = {2'b00, rt_n, 2'b01};
        if (rm_n >= trial) begin
          rm_n = rm_n - trial;
          rt_n = {rt_n[30:0], 1'b1};
        end else begin
          rt_n = {rt_n[30:0], 1'b0};
        end
        // restoring divide by n, one quotient bit
        dr_n = {dr_n[NW-1:0], dd_n[31]};
        dd_n = {dd_n[30:0], 1'b0};
        if (dr_n >= {1'b0, n_eff}) begin
          dr_n = dr_n - {1'b0, n_eff};
          dq_n = {dq_n[30:0], 1'b1};
        end else begin
          dq_n = {dq_n[30:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v_p[k+1] <= 1'b0;
      end else begin
        v_p[k+1] <= v_p[k];
      end
      ang_p[k+1] <= ang_p[k];
      rad_p[k+1] <= rad_n;
      rm_p[k+1]  <= rm_n;
      rt_p[k+1]  <= rt_n;
      dd_p[k+1]  <= dd_n;
      dr_p[k+1]  <= dr_n;
      dq_p[k+1]  <= dq_n;
      dn_p[k+1]  <= dn_p[k];
    end
  end

  // radius is at most 1.0 in Q30
  logic [30:0] mag;
  logic [31:0] delta;
  assign mag   = rt_p[NR][30:0];
  assign delta = dn_p[NR] ? (~dq_p[NR] + 32'd1) : dq_p[NR];

  logic               pt_valid;
  logic               off_valid;
  logic signed [33:0] cx;
  logic signed [33:0] sy;
  logic signed [33:0] lc;

  aps_cordic u_point (
    .clk      (clk),
    .rst      (rst),
    .in_valid (v_p[NR]),
    .ang      (ang_p[NR]),
    .mag      (mag),
    .out_valid(pt_valid),
    .cx       (cx),
    .sy       (sy)
  );

  // offset rotation: only the cosine is needed
  aps_cordic u_offset (
    .clk      (clk),
    .rst      (rst),
    .in_valid (v_p[NR]),
    .ang      (delta),
    .mag      (mag),
    .out_valid(off_valid),
    .cx       (lc),
    .sy       ()
  );

  // per-blade-count constants
  logic signed [33:0] rc_tab   [MAX_BLADES+1];
  logic [15:0]        dens_tab [MAX_BLADES+1];

  for (genvar n = 0; n <= MAX_BLADES; n++) begin : g_tab
    assign rc_tab[n]   = 34'(aps_pkg::rc_const((n < 3) ? 3 : n));
    assign dens_tab[n] = aps_pkg::dens_const((n < 3) ? 3 : n);
  end

  function automatic logic signed [23:0] to_q22(logic signed [33:0] v);
    logic signed [33:0] q;
    q = (v + 34'sd128) >>> 8;
    if (q > 34'sd4194304) q = 34'sd4194304;
    if (q < -34'sd4194304) q = -34'sd4194304;
    return q[23:0];
  endfunction

  // output stage
  logic disk_mode;
  logic in_poly;
  assign disk_mode = (blade_count == 5'd0);
  assign in_poly   = (lc <= rc_tab[n_eff]);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= pt_valid && off_valid;
    end
    result.x_coord    <= to_q22(cx);
    result.y_coord    <= to_q22(sy);
    result.inside_res <= disk_mode || in_poly;
    if (disk_mode) begin
      result.density <= aps_pkg::DISK_DENSITY;
    end else if (in_poly) begin
      result.density <= dens_tab[n_eff];
    end else begin
      result.density <= '0;
    end
  end

endmodule

/* sv/aps_cordic.sv */
// Pipelined rotation CORDIC: magnitude and 32-bit turn angle to cos and sin in Q30.
module aps_cordic (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic [31:0]        ang,
  input  logic [30:0]        mag,
  output logic               out_valid,
  output logic signed [33:0] cx,
  output logic signed [33:0] sy
);

  localparam int NS = aps_pkg::CORDIC_STAGES;

  logic               vs [NS+1];
  logic signed [33:0] xs [NS+1];
  logic signed [33:0] ys [NS+1];
  logic signed [32:0] zs [NS+1];
  logic [1:0]         qs [NS+1];
  logic [60:0]        prod;

  assign prod = 61'(mag) * 61'(aps_pkg::GAIN_Q30);

  // gain-compensated start value
  always_ff @(posedge clk) begin
    if (rst) begin
      vs[0] <= 1'b0;
    end else begin
      vs[0] <= in_valid;
    end
    xs[0] <= $signed({3'b000, prod[60:30]});
    ys[0] <= '0;
    zs[0] <= $signed({3'b000, ang[29:0]});
    qs[0] <= ang[31:30];
  end

  for (genvar k = 0; k < NS; k++) begin : g_stage
    logic signed [33:0] xn;
    logic signed [33:0] yn;
    logic signed [32:0] zn;

    always_comb begin
      logic signed [33:0] dx;
      logic signed [33:0] dy;
      xn = xs[k];
      yn = ys[k];
      zn = zs[k];
      for (int j = 0; j < aps_pkg::STEPS_PER_STAGE; j++) begin
        dx = yn >>> (k * aps_pkg::STEPS_PER_STAGE + j);
        dy = xn >>> (k * aps_pkg::STEPS_PER_STAGE + j);
        if (!zn[32]) begin
          xn = xn - dx;
          yn = yn + dy;
          zn = zn - $signed({3'b000,
                 aps_pkg::STEP_TURNS[k * aps_pkg::STEPS_PER_STAGE + j]});
        end else begin
          xn = xn + dx;
          yn = yn - dy;
          zn = zn + $signed({3'b000,
                 aps_pkg::STEP_TURNS[k * aps_pkg::STEPS_PER_STAGE + j]});
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vs[k+1] <= 1'b0;
      end else begin
        vs[k+1] <= vs[k];
      end
      xs[k+1] <= xn;
      ys[k+1] <= yn;
      zs[k+1] <= zn;
      qs[k+1] <= qs[k];
    end
  end

  // quadrant fold
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= vs[NS];
    end
    case (qs[NS])
      2'd0:    begin cx <= xs[NS];  sy <= ys[NS];  end
      2'd1:    begin cx <= -ys[NS]; sy <= xs[NS];  end
      2'd2:    begin cx <= -xs[NS]; sy <= -ys[NS]; end
      default: begin cx <= ys[NS];  sy <= -xs[NS]; end
    endcase
  end

endmodule

/* sv/aps_checker.sv */
// Port-level checks for the aperture point sampler, bound to the top level.
module aps_checker (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic              done,
  input aps_pkg::aps_out_t result
);

  a_no_busy: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("busy raised");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##(aps_pkg::LATENCY) done)
    else $error("result missing after accepted transaction");

  a_no_extra: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, aps_pkg::LATENCY))
    else $error("result without transaction");

  a_reject_density: assert property (@(posedge clk) disable iff (rst)
    (done && !result.inside_res) |-> (result.density == 16'd0))
    else $error("rejected sample carries density");

  a_coord_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.x_coord <= 24'sd4194304 && result.x_coord >= -24'sd4194304 &&
              result.y_coord <= 24'sd4194304 && result.y_coord >= -24'sd4194304))
    else $error("coordinate out of range");

endmodule

bind aperture_point_sampler aps_checker u_aps_checker (.*);
